[design/bpa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

	localparam int ORDERS         = 11;
	localparam int TOP_ORDER      = ORDERS - 1;
	localparam int MAX_TOP_BLOCKS = 16;
	localparam int TOTAL_PAGES    = MAX_TOP_BLOCKS << TOP_ORDER;
	localparam int IDX_W          = $clog2(TOTAL_PAGES);
	localparam int LVL_W          = $clog2(ORDERS);
	localparam int BLK_W          = $clog2(MAX_TOP_BLOCKS);
	localparam int TN_W           = $clog2(MAX_TOP_BLOCKS + 1);

	localparam int FRAME_W   = 20;
	localparam int ORDER_W   = 4;
	localparam int STATUS_W  = 2;
	localparam int CNT_W     = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_BLOCK     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_ORDER    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_BASE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'b1;

	typedef struct packed {
		logic               op;
		logic [ORDER_W-1:0] order;
		logic [FRAME_W-1:0] page_frame;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FRAME_W-1:0]  block_frame;
	} out_item_t;

	typedef struct packed {
		logic             toggle;
		logic [IDX_W-1:0] prev;
		logic             pv;
		logic [IDX_W-1:0] next;
		logic             nv;
	} link_word_t;

	localparam int LINK_W = $bits(link_word_t);

	typedef struct packed {
		logic                op;
		logic [LVL_W-1:0]    lvl;
		logic [IDX_W-1:0]    idx;
		logic [STATUS_W-1:0] status;
	} req_t;

	typedef struct packed {
		logic                alloc;
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    idx;
	} rsp_t;

endpackage

`default_nettype wire

[design/bpa_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module bpa_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [DATA_W-1:0]        wmask,
	input  wire logic [DATA_W-1:0]        wdata,
	output logic      [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			for (int i = 0; i < DATA_W; i++) begin
				if (wmask[i]) begin
					mem[addr][i] <= wdata[i];
				end
			end
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

[design/bpa_engine.sv]
`timescale 1ns / 1ps
`default_nettype none

module bpa_engine (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       rebuild,
	input  wire logic [bpa_pkg::TN_W-1:0]   top_n,
	input  wire logic                       start,
	input  wire bpa_pkg::req_t              req,
	output logic                            ready,
	output logic                            rsp_valid,
	input  wire logic                       rsp_take,
	output bpa_pkg::rsp_t                   rsp
);

	localparam int IDX_W = bpa_pkg::IDX_W;
	localparam int LVL_W = bpa_pkg::LVL_W;
	localparam int BLK_W = bpa_pkg::BLK_W;
	localparam int TOP   = bpa_pkg::TOP_ORDER;
	localparam int NORD  = bpa_pkg::ORDERS;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_SCAN, S_U_RD, S_U_EV, S_U_W2, S_U_CLR,
		S_F_RD, S_F_EV, S_P_W1, S_P_W2, S_DONE
	} state_t;

	state_t                          state_q;
	logic [LVL_W-1:0]                lvl_q;
	logic [LVL_W-1:0]                k_q;
	logic                            op_q;
	logic [IDX_W-1:0]                n_q;
	logic [IDX_W-1:0]                b_q;
	logic [IDX_W-1:0]                nx_q;
	logic [IDX_W-1:0]                pr_q;
	logic [bpa_pkg::STATUS_W-1:0]    st_q;
	logic [IDX_W-1:0]                clr_q;
	logic [IDX_W-1:0]                head_q [NORD];
	logic                            hv_q [NORD];

	logic                        ram_we;
	logic                        ram_re;
	logic [IDX_W-1:0]            ram_addr;
	bpa_pkg::link_word_t         ram_mask;
	bpa_pkg::link_word_t         ram_wdata;
	logic [bpa_pkg::LINK_W-1:0]  ram_rdata;
	bpa_pkg::link_word_t         rd;

	logic [IDX_W-1:0] cur_head;
	logic             cur_hv;
	logic [IDX_W-1:0] size;
	logic [IDX_W:0]   pos_full;
	logic [IDX_W:0]   pos_base;
	logic [IDX_W-1:0] pos;
	logic [IDX_W-1:0] even;
	logic [IDX_W-1:0] buddy;
	logic [LVL_W:0]   lvl_up;
	logic             tog_new;

	logic [BLK_W-1:0]    blk;
	logic                in_use;
	bpa_pkg::link_word_t cw;
	logic [IDX_W-1:0]    top_head;
	logic [bpa_pkg::TN_W-1:0] top_last;

	bpa_ram #(
		.DATA_W(bpa_pkg::LINK_W),
		.DEPTH (bpa_pkg::TOTAL_PAGES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wmask(ram_mask),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign rd       = bpa_pkg::link_word_t'(ram_rdata);
	assign cur_head = head_q[lvl_q];
	assign cur_hv   = hv_q[lvl_q];
	assign size     = IDX_W'(1) << lvl_q;
	assign lvl_up   = {1'b0, lvl_q} + (LVL_W+1)'(1);
	assign pos_full = (IDX_W+1)'(bpa_pkg::TOTAL_PAGES);
	assign pos_base = pos_full - (pos_full >> lvl_q);
	assign pos      = pos_base[IDX_W-1:0] + (n_q >> lvl_up);
	assign even     = (n_q >> lvl_up) << lvl_up;
	assign buddy    = (n_q == even) ? n_q + size : n_q - size;
	assign tog_new  = ~rd.toggle;

	assign blk      = clr_q[IDX_W-1:TOP];
	assign in_use   = (clr_q[TOP-1:0] == '0) && (32'(blk) < 32'(top_n));
	assign top_last = top_n - bpa_pkg::TN_W'(1);
	assign top_head = {top_last[BLK_W-1:0], {TOP{1'b0}}};

	always_comb begin
		cw        = '0;
		cw.next   = {blk - BLK_W'(1), {TOP{1'b0}}};
		cw.nv     = in_use && (blk != '0);
		cw.prev   = {blk + BLK_W'(1), {TOP{1'b0}}};
		cw.pv     = in_use && ((32'(blk) + 32'd1) < 32'(top_n));
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = n_q;
		ram_mask  = '0;
		ram_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_mask  = '1;
				ram_wdata = cw;
			end
			S_U_RD: begin
				ram_re   = 1'b1;
				ram_addr = b_q;
			end
			S_U_EV: begin
				if (rd.pv) begin
					ram_we         = 1'b1;
					ram_addr       = rd.prev;
					ram_mask.next  = '1;
					ram_mask.nv    = 1'b1;
					ram_wdata.next = rd.next;
					ram_wdata.nv   = rd.nv;
				end else if (cur_hv && cur_head == b_q && rd.nv) begin
					ram_we      = 1'b1;
					ram_addr    = rd.next;
					ram_mask.pv = 1'b1;
				end
			end
			S_U_W2: begin
				ram_we         = 1'b1;
				ram_addr       = nx_q;
				ram_mask.prev  = '1;
				ram_mask.pv    = 1'b1;
				ram_wdata.prev = pr_q;
				ram_wdata.pv   = 1'b1;
			end
			S_U_CLR: begin
				ram_we      = 1'b1;
				ram_addr    = b_q;
				ram_mask.nv = 1'b1;
				ram_mask.pv = 1'b1;
			end
			S_F_RD: begin
				ram_re   = 1'b1;
				ram_addr = pos;
			end
			S_F_EV: begin
				ram_we           = 1'b1;
				ram_addr         = pos;
				ram_mask.toggle  = 1'b1;
				ram_wdata.toggle = tog_new;
			end
			S_P_W1: begin
				ram_we         = 1'b1;
				ram_addr       = n_q;
				ram_mask.next  = '1;
				ram_mask.nv    = 1'b1;
				ram_mask.pv    = 1'b1;
				ram_wdata.next = cur_head;
				ram_wdata.nv   = cur_hv;
			end
			S_P_W2: begin
				ram_we         = 1'b1;
				ram_addr       = cur_head;
				ram_mask.prev  = '1;
				ram_mask.pv    = 1'b1;
				ram_wdata.prev = n_q;
				ram_wdata.pv   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			for (int o = 0; o < NORD; o++) begin
				hv_q[o]   <= 1'b0;
				head_q[o] <= '0;
			end
		end else if (rebuild) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					for (int o = 0; o < NORD; o++) begin
						if (o == TOP) begin
							hv_q[o]   <= (top_n != '0);
							head_q[o] <= top_head;
						end else begin
							hv_q[o]   <= 1'b0;
							head_q[o] <= '0;
						end
					end
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q  <= req.op;
						lvl_q <= req.lvl;
						k_q   <= req.lvl;
						n_q   <= req.idx;
						st_q  <= req.status;
						if (req.status != bpa_pkg::ST_OK) begin
							state_q <= S_DONE;
						end else if (req.op == bpa_pkg::OP_ALLOC) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_F_RD;
						end
					end
				end
				S_SCAN: begin
					if (cur_hv) begin
						n_q     <= cur_head;
						b_q     <= cur_head;
						state_q <= S_U_RD;
					end else if (lvl_q == LVL_W'(TOP)) begin
						st_q    <= bpa_pkg::ST_NO_BLOCK;
						state_q <= S_DONE;
					end else begin
						lvl_q <= lvl_q + LVL_W'(1);
					end
				end
				S_U_RD: begin
					state_q <= S_U_EV;
				end
				S_U_EV: begin
					nx_q <= rd.next;
					pr_q <= rd.prev;
					if (rd.pv) begin
						state_q <= rd.nv ? S_U_W2 : S_U_CLR;
					end else begin
						if (cur_hv && cur_head == b_q) begin
							if (rd.nv) begin
								head_q[lvl_q] <= rd.next;
							end else begin
								hv_q[lvl_q]   <= 1'b0;
								head_q[lvl_q] <= '0;
							end
						end
						state_q <= S_U_CLR;
					end
				end
				S_U_W2: begin
					state_q <= S_U_CLR;
				end
				S_U_CLR: begin
					if (op_q == bpa_pkg::OP_FREE) begin
						if (b_q < n_q) begin
							n_q <= b_q;
						end
						lvl_q <= lvl_q + LVL_W'(1);
					end
					state_q <= S_F_RD;
				end
				S_F_RD: begin
					state_q <= S_F_EV;
				end
				S_F_EV: begin
					if (op_q == bpa_pkg::OP_ALLOC) begin
						if (lvl_q == k_q) begin
							state_q <= S_DONE;
						end else begin
							lvl_q   <= lvl_q - LVL_W'(1);
							state_q <= S_P_W1;
						end
					end else if (!tog_new && lvl_q != LVL_W'(TOP)) begin
						b_q     <= buddy;
						state_q <= S_U_RD;
					end else begin
						state_q <= S_P_W1;
					end
				end
				S_P_W1: begin
					if (cur_hv) begin
						state_q <= S_P_W2;
					end else begin
						hv_q[lvl_q]   <= 1'b1;
						head_q[lvl_q] <= n_q;
						if (op_q == bpa_pkg::OP_ALLOC) begin
							n_q     <= n_q + size;
							state_q <= S_F_RD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_P_W2: begin
					hv_q[lvl_q]   <= 1'b1;
					head_q[lvl_q] <= n_q;
					if (op_q == bpa_pkg::OP_ALLOC) begin
						n_q     <= n_q + size;
						state_q <= S_F_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign ready      = (state_q == S_IDLE);
	assign rsp_valid  = (state_q == S_DONE);
	assign rsp.alloc  = (op_q == bpa_pkg::OP_ALLOC);
	assign rsp.status = st_q;
	assign rsp.idx    = n_q;

endmodule

`default_nettype wire

[design/buddy_page_allocator.sv]
// Channel   Signals                          Transfer when
// in        in_valid, in_stall, in_data      in_valid && !in_stall
// out       out_valid, out_stall, out_data   out_valid && !out_stall
// cfg       cfg_we, cfg_idx, cfg_wdata       cfg_we
//
// One item is processed at a time by a sequencer around a single-port link memory.
// Allocate scans empty orders upward, then splits the block down to the requested order.
// Free merges the block with its buddy, level by level, while the buddy is also free.
// After reset and after every register write, a clearing pass rebuilds the free lists.
// A result waits in the output register under stall while the next item is accepted.
`timescale 1ns / 1ps
`default_nettype none

module buddy_page_allocator (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire bpa_pkg::in_item_t               in_data,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output bpa_pkg::out_item_t                   out_data,
	input  wire logic                            cfg_we,
	input  wire logic [bpa_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [bpa_pkg::FRAME_W-1:0]     cfg_wdata
);

	localparam int FRAME_W = bpa_pkg::FRAME_W;
	localparam int TN_W    = bpa_pkg::TN_W;

	logic [FRAME_W-1:0]        base_q;
	logic [bpa_pkg::CNT_W-1:0] count_q;
	logic [TN_W-1:0]           top_n;
	logic                      rebuild;

	logic                  eng_ready;
	logic                  start;
	bpa_pkg::req_t         req;
	logic                  rsp_valid;
	logic                  rsp_take;
	bpa_pkg::rsp_t         rsp;

	logic [FRAME_W-1:0]    diff;
	logic [FRAME_W-1:0]    limit;
	logic                  bad_order;
	logic                  out_range;

	logic                  out_valid_q;
	bpa_pkg::out_item_t    out_data_q;

	assign top_n = (32'(count_q) > bpa_pkg::MAX_TOP_BLOCKS) ?
		TN_W'(bpa_pkg::MAX_TOP_BLOCKS) : TN_W'(count_q);

	always_comb begin
		rebuild = 1'b0;
		case (cfg_idx)
			bpa_pkg::REG_BASE:  rebuild = cfg_we;
			bpa_pkg::REG_COUNT: rebuild = cfg_we;
			default:            rebuild = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			count_q <= bpa_pkg::CNT_W'(bpa_pkg::MAX_TOP_BLOCKS);
		end else if (cfg_we) begin
			case (cfg_idx)
				bpa_pkg::REG_BASE:  base_q  <= cfg_wdata;
				bpa_pkg::REG_COUNT: count_q <= cfg_wdata[bpa_pkg::CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_stall  = !eng_ready;
	assign start     = in_valid && eng_ready;
	assign diff      = in_data.page_frame - base_q;
	assign limit     = FRAME_W'({top_n, {bpa_pkg::TOP_ORDER{1'b0}}});
	assign bad_order = 32'(in_data.order) >= bpa_pkg::ORDERS;
	assign out_range = (in_data.page_frame < base_q) || (diff >= limit);

	always_comb begin
		req.op  = in_data.op;
		req.lvl = in_data.order[bpa_pkg::LVL_W-1:0];
		req.idx = diff[bpa_pkg::IDX_W-1:0];
		if (bad_order) begin
			req.status = bpa_pkg::ST_BAD_ORDER;
		end else if (in_data.op == bpa_pkg::OP_FREE && out_range) begin
			req.status = bpa_pkg::ST_OUT_OF_RANGE;
		end else begin
			req.status = bpa_pkg::ST_OK;
		end
	end

	bpa_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.rebuild  (rebuild),
		.top_n    (top_n),
		.start    (start),
		.req      (req),
		.ready    (eng_ready),
		.rsp_valid(rsp_valid),
		.rsp_take (rsp_take),
		.rsp      (rsp)
	);

	assign rsp_take = rsp_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_take) begin
			out_data_q.status <= rsp.status;
			if (rsp.alloc && rsp.status == bpa_pkg::ST_OK) begin
				out_data_q.block_frame <= base_q + FRAME_W'(rsp.idx);
			end else begin
				out_data_q.block_frame <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

[design/bpa_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module bpa_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire bpa_pkg::out_item_t out_data
);

	logic [1:0] pending_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_xfer && !in_xfer) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result presented with no item outstanding");

	a_at_most_two: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two items outstanding");

	a_error_zero_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != bpa_pkg::ST_OK |-> out_data.block_frame == '0)
		else $error("failed transfer carries a nonzero frame");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (.*);

`default_nettype wire
